>>> rtl/core/cc_pkg.sv
// Shared types, constants and helpers for the ChaCha20 stream cipher core.
package cc_pkg;

    localparam int WORD_W        = 32;
    localparam int DATA_W        = 8;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int POS_W         = 6;
    localparam int NUM_WORDS     = 16;
    localparam int DOUBLE_ROUNDS = 10;
    localparam int STEPS_PER_DR  = 16;   // 8 quarter rounds, two halves each
    localparam int STEP_W        = 8;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DOUBLE_ROUNDS * STEPS_PER_DR - 1);

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_block [NUM_WORDS];

    localparam t_word SIGMA0 = 32'h6170_7865;
    localparam t_word SIGMA1 = 32'h3320_646e;
    localparam t_word SIGMA2 = 32'h7962_2d32;
    localparam t_word SIGMA3 = 32'h6b20_6574;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0       = 3'd0,
        CFG_KEY1       = 3'd1,
        CFG_KEY2       = 3'd2,
        CFG_KEY3       = 3'd3,
        CFG_NONCE_LOW  = 3'd4,
        CFG_NONCE_HIGH = 3'd5,
        CFG_START_CTR  = 3'd6
    } t_cfg_idx;

    function automatic t_word rotl(input t_word v, input int s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

endpackage

>>> rtl/core/cc_in_if.sv
// Input byte channel: valid/ready handshake with data byte and end flag.
interface cc_in_if;
    import cc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_in;
    logic              end_flag;

    modport source (output valid, output data_in, output end_flag, input ready);
    modport sink   (input valid, input data_in, input end_flag, output ready);
endinterface

>>> rtl/core/cc_out_if.sv
// Output byte channel: valid/ready handshake with result byte and end flag.
interface cc_out_if;
    import cc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              end_out;

    modport source (output valid, output data_out, output end_out, input ready);
    modport sink   (input valid, input data_out, input end_out, output ready);
endinterface

>>> rtl/core/cc_half_round.sv
// Shared half quarter-round unit: two add-xor-rotate steps on one column.
module cc_half_round (
    input  logic         i_second,
    input  cc_pkg::t_word i_a,
    input  cc_pkg::t_word i_b,
    input  cc_pkg::t_word i_c,
    input  cc_pkg::t_word i_d,
    output cc_pkg::t_word o_a,
    output cc_pkg::t_word o_b,
    output cc_pkg::t_word o_c,
    output cc_pkg::t_word o_d
);
    import cc_pkg::*;

    t_word a_sum;
    t_word d_mix;
    t_word c_sum;
    t_word b_mix;

    assign a_sum = i_a + i_b;
    assign d_mix = i_d ^ a_sum;
    assign o_d   = i_second ? rotl(d_mix, 8) : rotl(d_mix, 16);
    assign c_sum = i_c + o_d;
    assign b_mix = i_b ^ c_sum;
    assign o_b   = i_second ? rotl(b_mix, 7) : rotl(b_mix, 12);
    assign o_a   = a_sum;
    assign o_c   = c_sum;

endmodule

>>> rtl/core/chacha20_stream_cipher_core.sv
// ChaCha20 byte-stream cipher core (96-bit nonce, 32-bit block counter).
// Each accepted byte is XORed with the next keystream byte; encrypt and
// decrypt are the same transaction. Bytes at block positions 1 to 63 use the
// held keystream block. A byte at position 0 first builds a new 64-byte block on
// a single shared half-quarter-round unit: 160 steps for the 20 rounds, one
// add-back step and one output step that waits for the output register to be
// free; no byte is accepted meanwhile. A byte flagged as end of
// message restarts the next message at the start counter. Configuration
// (key, nonce, start counter) is written through the index/data write port
// and is read at the start of each block generation and again at its add-back.
module chacha20_stream_cipher_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cc_in_if.sink                        i_in,
    cc_out_if.source                     o_out,
    input  logic                         i_cfg_we,
    input  logic [cc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cc_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import cc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_key0, r_key1, r_key2, r_key3, r_nonce_low;
    t_word               r_nonce_high;
    t_word               r_start_ctr;
    t_word               r_blk_idx;
    logic [POS_W-1:0]    r_pos;
    t_word               r_ctr;
    logic [STEP_W-1:0]   r_step;
    logic [DATA_W-1:0]   r_data;
    logic                r_last;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_end;
    t_block              r_work;
    t_block              n_work;

    t_block              init_blk;
    t_block              mixed;
    t_word               blk_ctr;
    t_word               qa, qb, qc, qd;
    logic                in_fire;
    logic                out_free;
    logic [1:0]          rot_amt [4];
    logic [1:0]          src_col;
    logic [DATA_W-1:0]   ks_byte;
    logic [POS_W-1:0]    pos_inc;

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_out_data;
    assign o_out.end_out  = r_out_end;

    assign pos_inc = r_pos + POS_W'(1);
    assign ks_byte = r_work[r_pos[5:2]][{r_pos[1:0], 3'b000} +: DATA_W];

    // Counter word: fresh sum at acceptance, latched copy for the add-back.
    assign blk_ctr = (r_state == S_IDLE) ? (r_start_ctr + r_blk_idx) : r_ctr;

    always_comb begin
        init_blk[0]  = SIGMA0;
        init_blk[1]  = SIGMA1;
        init_blk[2]  = SIGMA2;
        init_blk[3]  = SIGMA3;
        init_blk[4]  = r_key0[31:0];
        init_blk[5]  = r_key0[63:32];
        init_blk[6]  = r_key1[31:0];
        init_blk[7]  = r_key1[63:32];
        init_blk[8]  = r_key2[31:0];
        init_blk[9]  = r_key2[63:32];
        init_blk[10] = r_key3[31:0];
        init_blk[11] = r_key3[63:32];
        init_blk[12] = blk_ctr;
        init_blk[13] = r_nonce_low[31:0];
        init_blk[14] = r_nonce_low[63:32];
        init_blk[15] = r_nonce_high;
    end

    cc_half_round u_half_round (
        .i_second (r_step[0]),
        .i_a      (r_work[0]),
        .i_b      (r_work[4]),
        .i_c      (r_work[8]),
        .i_d      (r_work[12]),
        .o_a      (qa),
        .o_b      (qb),
        .o_c      (qc),
        .o_d      (qd)
    );

    // The unit always works on column 0. After a full quarter round, rotate
    // every row left by one; at the end of the column pass also diagonalize
    // (row r by r more), and at the end of the diagonal pass undo it.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            if (r_step[2:1] != 2'd3) begin
                rot_amt[r] = 2'd1;
            end else if (!r_step[3]) begin
                rot_amt[r] = 2'(r + 1);
            end else begin
                rot_amt[r] = 2'(1 - r);
            end
        end
    end

    always_comb begin
        mixed     = r_work;
        mixed[0]  = qa;
        mixed[4]  = qb;
        mixed[8]  = qc;
        mixed[12] = qd;
        src_col   = 2'd0;
        n_work    = r_work;
        case (r_state)
            S_IDLE: begin
                if (in_fire && (r_pos == '0)) begin
                    n_work = init_blk;
                end
            end
            S_ROUND: begin
                if (r_step[0]) begin
                    for (int r = 0; r < 4; r++) begin
                        for (int c = 0; c < 4; c++) begin
                            src_col = 2'(c) + rot_amt[r];
                            n_work[4 * r + c] = mixed[4 * r + int'(src_col)];
                        end
                    end
                end else begin
                    n_work = mixed;
                end
            end
            S_ADD: begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                    n_work[i] = r_work[i] + init_blk[i];
                end
            end
            default: begin
                n_work = r_work;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key0       <= '0;
            r_key1       <= '0;
            r_key2       <= '0;
            r_key3       <= '0;
            r_nonce_low  <= '0;
            r_nonce_high <= '0;
            r_start_ctr  <= '0;
            r_blk_idx    <= '0;
            r_pos        <= '0;
            r_ctr        <= '0;
            r_step       <= '0;
            r_data       <= '0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_data   <= '0;
            r_out_end    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY0:       r_key0       <= i_cfg_wdata;
                    CFG_KEY1:       r_key1       <= i_cfg_wdata;
                    CFG_KEY2:       r_key2       <= i_cfg_wdata;
                    CFG_KEY3:       r_key3       <= i_cfg_wdata;
                    CFG_NONCE_LOW:  r_nonce_low  <= i_cfg_wdata;
                    CFG_NONCE_HIGH: r_nonce_high <= i_cfg_wdata[WORD_W-1:0];
                    CFG_START_CTR:  r_start_ctr  <= i_cfg_wdata[WORD_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Drop the held result once the sink takes it.
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_data <= i_in.data_in;
                        r_last <= i_in.end_flag;
                        if (i_in.end_flag) begin
                            r_pos     <= '0;
                            r_blk_idx <= '0;
                        end else begin
                            r_pos <= pos_inc;
                            if (pos_inc == '0) begin
                                r_blk_idx <= r_blk_idx + 32'd1;
                            end
                        end
                        if (r_pos == '0) begin
                            r_ctr   <= blk_ctr;
                            r_step  <= '0;
                            r_state <= S_ROUND;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= i_in.data_in ^ ks_byte;
                            r_out_end   <= i_in.end_flag;
                        end
                    end
                end
                S_ROUND: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == LAST_STEP) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Fresh block: the byte uses keystream byte 0.
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_data ^ r_work[0][DATA_W-1:0];
                        r_out_end   <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sim/chacha20_stream_cipher_core_tb.sv
// Self-checking testbench for the ChaCha20 byte-stream cipher core with a built-in keystream predictor.
module chacha20_stream_cipher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cc_pkg::*;

    typedef logic [31:0]          word_t;
    typedef logic [DATA_W-1:0]    byte_t;
    typedef logic [CFG_W-1:0]     reg_value_t;
    typedef logic [CFG_IDX_W-1:0] reg_index_t;

    typedef struct packed {
        byte_t data;
        logic  last;
    } cipher_byte_t;

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

    localparam reg_index_t CFG_UNUSED   = 3'd7;   // no register here: the write is dropped
    localparam int         BLOCK_BYTES  = 64;
    localparam int         ROUND_PAIRS  = 10;
    localparam int         BLOCK_CYCLES = 200;    // one keystream build plus margin
    localparam int         MAX_IDLE     = 10;
    localparam int         RANDOM_BYTES = 520;
    localparam int         MAX_REPORTS  = 20;
    localparam word_t      CONST_EXPA   = 32'h6170_7865;
    localparam word_t      CONST_ND_3   = 32'h3320_646e;
    localparam word_t      CONST_2_BY   = 32'h7962_2d32;
    localparam word_t      CONST_TE_K   = 32'h6b20_6574;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    reg_index_t cfg_index;
    reg_value_t cfg_wdata;

    cc_in_if  in_bus ();
    cc_out_if out_bus ();

    chacha20_stream_cipher_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // predictor copy of the configuration and stream state
    reg_value_t key_part [4];
    reg_value_t nonce_lo;
    word_t      nonce_hi;
    word_t      first_counter;
    word_t      blocks_done;
    logic [5:0] stream_pos;
    word_t      keystream [16];
    word_t      mix [16];

    cipher_byte_t expected_bytes [$];

    bit src_gaps;
    bit sink_stalls;
    int errors;
    int bytes_sent;
    int messages;
    int blocks_built;
    int reg_writes;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("%0t: watchdog expired, traffic did not drain", $realtime);
        $display("TB_ERROR");
        $finish;
    end

    function automatic void mix_quarter(input int a, input int b, input int c, input int d);
        word_t wa, wb, wc, wd;
        wa = mix[a];
        wb = mix[b];
        wc = mix[c];
        wd = mix[d];
        wa = wa + wb; wd = wd ^ wa; wd = {wd[15:0], wd[31:16]};
        wc = wc + wd; wb = wb ^ wc; wb = {wb[19:0], wb[31:20]};
        wa = wa + wb; wd = wd ^ wa; wd = {wd[23:0], wd[31:24]};
        wc = wc + wd; wb = wb ^ wc; wb = {wb[24:0], wb[31:25]};
        mix[a] = wa;
        mix[b] = wb;
        mix[c] = wc;
        mix[d] = wd;
    endfunction

    function automatic void build_keystream(input word_t counter);
        word_t seed [16];
        int    i;
        seed[0] = CONST_EXPA;
        seed[1] = CONST_ND_3;
        seed[2] = CONST_2_BY;
        seed[3] = CONST_TE_K;
        for (i = 0; i < 4; i++) begin
            seed[4 + 2 * i] = key_part[i][31:0];
            seed[5 + 2 * i] = key_part[i][63:32];
        end
        seed[12] = counter;
        seed[13] = nonce_lo[31:0];
        seed[14] = nonce_lo[63:32];
        seed[15] = nonce_hi;
        for (i = 0; i < 16; i++) mix[i] = seed[i];
        for (i = 0; i < ROUND_PAIRS; i++) begin
            mix_quarter(0, 4, 8, 12);
            mix_quarter(1, 5, 9, 13);
            mix_quarter(2, 6, 10, 14);
            mix_quarter(3, 7, 11, 15);
            mix_quarter(0, 5, 10, 15);
            mix_quarter(1, 6, 11, 12);
            mix_quarter(2, 7, 8, 13);
            mix_quarter(3, 4, 9, 14);
        end
        for (i = 0; i < 16; i++) keystream[i] = mix[i] + seed[i];
        blocks_built++;
    endfunction

    function automatic void predict_cipher(input byte_t din, input logic last);
        word_t        w;
        cipher_byte_t item;
        if (stream_pos == 0) build_keystream(first_counter + blocks_done);
        w = keystream[stream_pos[5:2]] >> {stream_pos[1:0], 3'b000};
        item.data = din ^ w[7:0];
        item.last = last;
        expected_bytes.push_back(item);
        if (last) begin
            stream_pos  = '0;
            blocks_done = '0;
        end else begin
            stream_pos = stream_pos + 1'b1;
            if (stream_pos == 0) blocks_done = blocks_done + 1;
        end
    endfunction

    function automatic void store_reg(input reg_index_t idx, input reg_value_t value);
        case (idx)
            CFG_KEY0:       key_part[0]   = value;
            CFG_KEY1:       key_part[1]   = value;
            CFG_KEY2:       key_part[2]   = value;
            CFG_KEY3:       key_part[3]   = value;
            CFG_NONCE_LOW:  nonce_lo      = value;
            CFG_NONCE_HIGH: nonce_hi      = value[31:0];
            CFG_START_CTR:  first_counter = value[31:0];
            default: ;
        endcase
    endfunction

    function automatic reg_value_t fill_value(input fill_t fill);
        case (fill)
            FILL_ZERO: return '0;
            FILL_ONES: return '1;
            default:   return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(input reg_index_t idx, input reg_value_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        store_reg(idx, value);
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic load_config(input fill_t fill, input word_t counter);
        write_reg(CFG_KEY0, fill_value(fill));
        write_reg(CFG_KEY1, fill_value(fill));
        write_reg(CFG_KEY2, fill_value(fill));
        write_reg(CFG_KEY3, fill_value(fill));
        write_reg(CFG_NONCE_LOW, fill_value(fill));
        write_reg(CFG_NONCE_HIGH, fill_value(fill));
        // upper half of the data bus is unused for the counter
        write_reg(CFG_START_CTR, {$urandom, counter});
    endtask

    // Call at a rising edge; returns at the edge where the transaction completed.
    task automatic send_byte(input byte_t din, input logic last);
        int gap;
        gap = src_gaps ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.data_in  <= din;
        in_bus.end_flag <= last;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        predict_cipher(din, last);
        bytes_sent++;
        if (last) messages++;
    endtask

    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Optionally pause partway through to write one random register index.
    task automatic send_message(input int len, input bit retune);
        int split;
        int i;
        split = (retune && len > 1) ? $urandom_range(1, len - 1) : 0;
        for (i = 0; i < len; i++) begin
            if (split > 0 && i == split) begin
                wait_idle();
                write_reg(reg_index_t'($urandom_range(0, CFG_UNUSED)), fill_value(FILL_RANDOM));
            end
            send_byte(byte_t'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic test_reset_values();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b1);
        wait_idle();
    endtask

    task automatic test_rfc_block();
        write_reg(CFG_KEY0, 64'h0706_0504_0302_0100);
        write_reg(CFG_KEY1, 64'h0f0e_0d0c_0b0a_0908);
        write_reg(CFG_KEY2, 64'h1716_1514_1312_1110);
        write_reg(CFG_KEY3, 64'h1f1e_1d1c_1b1a_1918);
        write_reg(CFG_NONCE_LOW, 64'h4a00_0000_0900_0000);
        write_reg(CFG_NONCE_HIGH, '0);
        write_reg(CFG_START_CTR, 64'd1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        wait_idle();
    endtask

    task automatic test_all_ones();
        load_config(FILL_ONES, '1);
        // single-byte messages: each restarts at the start counter
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h96, 1'b1);
        wait_idle();
    endtask

    task automatic test_midstream_write();
        load_config(FILL_RANDOM, $urandom);
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h5A, 1'b0);
        wait_idle();
        // current block must stay on the old key until the next build
        write_reg(CFG_KEY2, fill_value(FILL_RANDOM));
        write_reg(CFG_START_CTR, fill_value(FILL_RANDOM));
        write_reg(CFG_UNUSED, fill_value(FILL_ONES));
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7E, 1'b1);
        wait_idle();
    endtask

    task automatic test_counter_wrap();
        load_config(FILL_RANDOM, 32'hFFFF_FFFE);
        src_gaps    = 1'b0;
        sink_stalls = 1'b1;
        send_message(2 * BLOCK_BYTES + $urandom_range(1, 8), 1'b0);
        wait_idle();
    endtask

    task automatic test_random_messages();
        int    start_count;
        int    pick;
        int    len;
        word_t counter;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            pick        = $urandom_range(0, 3);
            src_gaps    = pick[0];
            sink_stalls = pick[1];
            pick        = $urandom_range(0, 5);
            counter     = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
            pick        = $urandom_range(0, 5);
            load_config(pick == 0 ? FILL_ZERO : pick == 1 ? FILL_ONES : FILL_RANDOM, counter);
            repeat ($urandom_range(1, 4)) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    len = $urandom_range(1, 16);
                end else if (pick < 9) begin
                    len = $urandom_range(17, BLOCK_BYTES - 1);
                end else begin
                    len = $urandom_range(BLOCK_BYTES, 140);
                end
                send_message(len, $urandom_range(0, 7) == 0);
            end
            wait_idle();
        end
    endtask

    initial begin : sink_ready
        int stall;
        forever begin
            stall = sink_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (out_bus.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : result_check
        cipher_byte_t want;
        if (i_rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected output byte: expected none, got data %02h end %0b",
                             $realtime, out_bus.data_out, out_bus.end_out);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (out_bus.data_out !== want.data) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: data_out mismatch: expected %02h, got %02h",
                                 $realtime, want.data, out_bus.data_out);
                    errors++;
                end
                if (out_bus.end_out !== want.last) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: end_out mismatch: expected %0b, got %0b",
                                 $realtime, want.last, out_bus.end_out);
                    errors++;
                end
            end
        end
    end

    initial begin
        in_bus.valid    <= 1'b0;
        in_bus.data_in  <= '0;
        in_bus.end_flag <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_wdata       <= '0;
        i_rst_n         <= 1'b0;
        for (int k = 0; k < 4; k++) key_part[k] = '0;
        nonce_lo      = '0;
        nonce_hi      = '0;
        first_counter = '0;
        blocks_done   = '0;
        stream_pos    = '0;
        src_gaps      = 1'b0;
        sink_stalls   = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_rfc_block();
        test_all_ones();
        test_midstream_write();
        test_counter_wrap();
        test_random_messages();

        wait_idle();
        repeat (BLOCK_CYCLES) @(posedge i_clk);
        $display("Run covered %0d bytes in %0d messages, %0d keystream blocks, %0d register writes",
                 bytes_sent, messages, blocks_built, reg_writes);
        $display("Keys: reset, RFC 8439 vector, all-ones, random; counter wrap and mid-message writes");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/cc_pkg.sv
rtl/core/cc_in_if.sv
rtl/core/cc_out_if.sv
rtl/core/cc_half_round.sv
rtl/core/chacha20_stream_cipher_core.sv
sim/chacha20_stream_cipher_core_tb.sv
